@@ src/atp_pkg.sv @@
// atp_pkg: constants, types and cordic helper functions for the tilt angle pipeline
`default_nettype none
package atp_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 12;
  localparam int TAB_LEN       = 24;
  localparam int NUM_ITER      = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  localparam int DW      = SAMPLE_BITS + GUARD + 3;
  localparam int ACC_W   = 25;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = DW - 1 + GAIN_W;
  localparam int INV_GAIN = 39796;
  localparam int DEG90   = 2949120;

  localparam int PITCH_W   = 15;
  localparam int ROLL_W    = 16;
  localparam int PITCH_LIM = 11520;
  localparam int ROLL_LIM  = 23040;

  localparam int IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((PITCH_W + ROLL_W + 7) / 8) * 8;

  // pipeline depth from input word to output register
  localparam int DEPTH = 2 * NUM_ITER + 4;

  typedef struct packed {
    logic signed [DW-1:0]    x;
    logic signed [DW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } vec_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
    logic signed [ACC_W-1:0] r;
    case (i)
      0:  r = ACC_W'(1474560);
      1:  r = ACC_W'(870484);
      2:  r = ACC_W'(459940);
      3:  r = ACC_W'(233473);
      4:  r = ACC_W'(117189);
      5:  r = ACC_W'(58652);
      6:  r = ACC_W'(29333);
      7:  r = ACC_W'(14667);
      8:  r = ACC_W'(7334);
      9:  r = ACC_W'(3667);
      10: r = ACC_W'(1833);
      11: r = ACC_W'(917);
      12: r = ACC_W'(458);
      13: r = ACC_W'(229);
      14: r = ACC_W'(115);
      15: r = ACC_W'(57);
      16: r = ACC_W'(29);
      17: r = ACC_W'(14);
      18: r = ACC_W'(7);
      19: r = ACC_W'(4);
      20: r = ACC_W'(2);
      21: r = ACC_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // quarter turn into the right half plane
  function automatic vec_t pre_rot(input logic signed [DW-1:0] px,
                                   input logic signed [DW-1:0] py);
    vec_t v;
    v.zero = (px == '0) && (py == '0);
    if (px[DW-1]) begin
      if (!py[DW-1]) begin
        v.x   = py;
        v.y   = -px;
        v.acc = ACC_W'(DEG90);
      end else begin
        v.x   = -py;
        v.y   = px;
        v.acc = -ACC_W'(DEG90);
      end
    end else begin
      v.x   = px;
      v.y   = py;
      v.acc = '0;
    end
    return v;
  endfunction

  function automatic vec_t micro_rot(input vec_t v, input int i);
    vec_t r;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    r.zero = v.zero;
    if (v.y > 0) begin
      r.x   = v.x + dx;
      r.y   = v.y - dy;
      r.acc = v.acc + atan_entry(i);
    end else begin
      r.x   = v.x - dx;
      r.y   = v.y + dy;
      r.acc = v.acc - atan_entry(i);
    end
    return r;
  endfunction

  // round to 1/128 degree and saturate
  function automatic logic signed [ROLL_W-1:0] to_angle(input logic signed [ACC_W-1:0] acc,
                                                        input int lim);
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W:0] sh;
    logic signed [ACC_W:0] lv;
    lv  = (ACC_W+1)'(lim);
    sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(128);
    sh  = sum >>> 8;
    if (sh > lv) begin
      sh = lv;
    end else if (sh < -lv) begin
      sh = -lv;
    end
    return sh[ROLL_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/accel_tilt_pitch_roll.sv @@
// accel_tilt_pitch_roll: pipelined cordic pitch and roll from a three-axis accelerometer word
//
//  port group   dir  tdata fields (low bit first)
//  s_axis_*     in   accel_x, accel_y, accel_z
//  m_axis_*     out  pitch_angle, roll_angle, zero pad
//
//  one word per cycle while the output register is not stalled
//  stages: pre-rotate, roll cordic, gain multiply, pre-rotate, pitch cordic, round
//  one enable moves every stage; it drops only when the output register holds an untaken word
//  rst clears the valid bits only
`default_nettype none
module accel_tilt_pitch_roll (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [atp_pkg::IN_W-1:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [atp_pkg::OUT_W-1:0]    m_axis_tdata    // pitch_angle, roll_angle, pad
);
  import atp_pkg::*;

  logic                     en;
  logic [DEPTH-1:0]         valid;

  logic [SAMPLE_BITS-1:0]   in_x;
  logic [SAMPLE_BITS-1:0]   in_y;
  logic [SAMPLE_BITS-1:0]   in_z;
  logic signed [DW-1:0]     sx;
  logic signed [DW-1:0]     sy;
  logic signed [DW-1:0]     sz;

  vec_t                     rc   [0:NUM_ITER];
  logic signed [DW-1:0]     nax  [0:NUM_ITER];

  logic [PROD_W-1:0]        prod;
  logic signed [DW-1:0]     nax_m;
  logic signed [ROLL_W-1:0] roll_m;

  vec_t                     pc    [0:NUM_ITER];
  logic signed [ROLL_W-1:0] rollp [0:NUM_ITER];

  logic signed [ROLL_W-1:0]  pitch_full;
  logic signed [PITCH_W-1:0] pitch_out;
  logic signed [ROLL_W-1:0]  roll_out;

  assign en            = !valid[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid[DEPTH-1];

  assign in_x = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_y = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_z = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  assign sx = {{(DW-SAMPLE_BITS-GUARD){in_x[SAMPLE_BITS-1]}}, in_x, {GUARD{1'b0}}};
  assign sy = {{(DW-SAMPLE_BITS-GUARD){in_y[SAMPLE_BITS-1]}}, in_y, {GUARD{1'b0}}};
  assign sz = {{(DW-SAMPLE_BITS-GUARD){in_z[SAMPLE_BITS-1]}}, in_z, {GUARD{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // roll: vector (z, y)
  always_ff @(posedge clk) begin
    if (en) begin
      rc[0]  <= pre_rot(sz, sy);
      nax[0] <= -sx;
    end
  end

  for (genvar k = 1; k <= NUM_ITER; k++) begin : g_roll
    always_ff @(posedge clk) begin
      if (en) begin
        rc[k]  <= micro_rot(rc[k-1], k - 1);
        nax[k] <= nax[k-1];
      end
    end
  end

  // magnitude times inverse gain, roll rounding
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= rc[NUM_ITER].x[DW-2:0] * GAIN_W'(INV_GAIN);
      nax_m  <= nax[NUM_ITER];
      roll_m <= rc[NUM_ITER].zero ? '0 : to_angle(rc[NUM_ITER].acc, ROLL_LIM);
    end
  end

  // pitch: vector (m, -x)
  always_ff @(posedge clk) begin
    if (en) begin
      pc[0]    <= pre_rot(signed'({1'b0, prod[PROD_W-1:GAIN_W]}), nax_m);
      rollp[0] <= roll_m;
    end
  end

  for (genvar k = 1; k <= NUM_ITER; k++) begin : g_pitch
    always_ff @(posedge clk) begin
      if (en) begin
        pc[k]    <= micro_rot(pc[k-1], k - 1);
        rollp[k] <= rollp[k-1];
      end
    end
  end

  assign pitch_full = pc[NUM_ITER].zero ? '0 : to_angle(pc[NUM_ITER].acc, PITCH_LIM);

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_out <= pitch_full[PITCH_W-1:0];
      roll_out  <= rollp[NUM_ITER];
    end
  end

  assign m_axis_tdata = {{(OUT_W-PITCH_W-ROLL_W){1'b0}}, roll_out, pitch_out};

`ifndef SYNTHESIS
  a_mag_nonneg: assert property (@(posedge clk) disable iff (rst)
    valid[NUM_ITER] |-> !rc[NUM_ITER].x[DW-1])
    else $error("roll magnitude negative");

  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    (valid[NUM_ITER] && rc[NUM_ITER].zero) |-> (rc[NUM_ITER].x == '0))
    else $error("zero pair left nonzero magnitude");

  a_pitch_no_prerot: assert property (@(posedge clk) disable iff (rst)
    valid[NUM_ITER+2] |-> (pc[0].acc == '0 && !pc[0].x[DW-1]))
    else $error("pitch vector left right half plane");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (roll_out <= ROLL_W'(ROLL_LIM) && roll_out >= -ROLL_W'(ROLL_LIM)))
    else $error("roll out of range");
`endif

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// testbench: checks accel_tilt_pitch_roll pitch and roll words against a cordic tilt model
`default_nettype none
module testbench;

  localparam int  IDLE_LIMIT = 4000;
  localparam int  SHIFT_IN   = 12;
  localparam int  ROT_COUNT  = (atp_pkg::CORDIC_STAGES < 24) ? atp_pkg::CORDIC_STAGES : 24;
  localparam longint QUARTER_TURN = 2949120;
  localparam longint GAIN_COMP    = 39796;
  localparam longint PITCH_MAX    = 11520;
  localparam longint ROLL_MAX     = 23040;
  localparam longint ATAN_STEP [0:23] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };
  localparam logic signed [15:0] EDGE_VALS [0:4] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                                                      16'shffff, 16'sh0001};

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } tilt_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [atp_pkg::IN_W-1:0]  s_axis_tdata = '0;   // accel_x, accel_y, accel_z
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [atp_pkg::OUT_W-1:0] m_axis_tdata;        // pitch_angle, roll_angle, pad

  tilt_t tilt_expected[$];
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_errors = 0;
  int    idle_count = 0;
  int    hold_cycles = 0;
  int    sink_wait = 0;
  bit    src_idle_on = 1'b1;
  bit    sink_idle_on = 1'b1;

  accel_tilt_pitch_roll uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // vectoring cordic: angle in 1/32768 degree, magnitude times cordic gain
  function automatic longint cordic_vector(input longint px, input longint py,
                                           output longint mag);
    longint vx;
    longint vy;
    longint acc;
    longint dx;
    longint dy;
    vx  = px;
    vy  = py;
    acc = 0;
    if (px == 0 && py == 0) begin
      mag = 0;
      return 0;
    end
    if (vx < 0) begin
      if (vy >= 0) begin
        vx  = py;
        vy  = -px;
        acc = QUARTER_TURN;
      end else begin
        vx  = -py;
        vy  = px;
        acc = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < ROT_COUNT; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx  += dx;
        vy  -= dy;
        acc += ATAN_STEP[i];
      end else begin
        vx  -= dx;
        vy  += dy;
        acc -= ATAN_STEP[i];
      end
    end
    mag = vx;
    return acc;
  endfunction

  function automatic longint round_angle(input longint acc, input longint lim);
    longint a;
    a = (acc + 128) >>> 8;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic tilt_t tilt_angles(input logic signed [15:0] x, input logic signed [15:0] y,
                                        input logic signed [15:0] z);
    tilt_t  t;
    longint ax;
    longint ay;
    longint az;
    longint mag;
    longint mag2;
    longint m;
    longint roll_acc;
    longint pitch_acc;
    ax = longint'(x) * (64'sd1 <<< SHIFT_IN);
    ay = longint'(y) * (64'sd1 <<< SHIFT_IN);
    az = longint'(z) * (64'sd1 <<< SHIFT_IN);
    roll_acc  = cordic_vector(az, ay, mag);
    m         = longint'((longint'(unsigned'(mag)) * GAIN_COMP) >>> 16);
    pitch_acc = cordic_vector(m, -ax, mag2);
    t.pitch = 15'(round_angle(pitch_acc, PITCH_MAX));
    t.roll  = 16'(round_angle(roll_acc, ROLL_MAX));
    return t;
  endfunction

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    int gap;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {x, y, z} == 48'h0 ? '0 : {z, y, x};
    do @(posedge clk); while (!s_axis_tready);
    tilt_expected.push_back(tilt_angles(x, y, z));
    n_sent++;
  endtask

  task automatic random_sample(output logic signed [15:0] x, output logic signed [15:0] y,
                               output logic signed [15:0] z);
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    case ($urandom_range(0, 9))
      6: begin
        x = 16'($signed($urandom_range(0, 8)) - 4);
        y = 16'($signed($urandom_range(0, 8)) - 4);
        z = 16'($signed($urandom_range(0, 8)) - 4);
      end
      7: begin
        y = '0;
        z = '0;
      end
      8: begin
        x = EDGE_VALS[$urandom_range(0, 4)];
        y = EDGE_VALS[$urandom_range(0, 4)];
        z = EDGE_VALS[$urandom_range(0, 4)];
      end
      9: y = '0;
      default: ;
    endcase
  endtask

  task automatic run_directed();
    send_sample(0, 0, 0);
    send_sample(16384, 0, 0);
    send_sample(-16384, 0, 0);
    send_sample(1, 0, 0);
    send_sample(-1, 0, 0);
    send_sample(32767, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(0, 0, -32768);
    send_sample(0, 0, -1);
    send_sample(0, 0, 32767);
    send_sample(0, 32767, 0);
    send_sample(0, -32768, 0);
    send_sample(0, -1, -32768);
    send_sample(0, 1, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 0);
    send_sample(-32768, 32767, -32768);
    send_sample(-32768, 0, 1);
    send_sample(0, 1, 1);
    send_sample(0, -1, -1);
    send_sample(0, 0, 16384);
  endtask

  task automatic run_random_mix(input int count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    repeat (count) begin
      random_sample(x, y, z);
      send_sample(x, y, z);
    end
  endtask

  // long output stall while the source keeps offering, so the pipeline backs up
  task automatic run_output_hold();
    src_idle_on = 1'b0;
    hold_cycles = 150;
    run_random_mix(80);
    src_idle_on = 1'b1;
  endtask

  task automatic run_back_to_back();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_random_mix(160);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      sink_wait   = hold_cycles;
      hold_cycles = 0;
    end else if (sink_wait == 0 && sink_idle_on && $urandom_range(0, 3) == 0) begin
      sink_wait = $urandom_range(1, 8);
    end
    if (sink_wait > 0) begin
      m_axis_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tilt_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (tilt_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = tilt_expected.pop_front();
        n_checked++;
        if ($signed(m_axis_tdata[14:0]) != want.pitch) begin
          $display("%0t: pitch mismatch, expected %0d, got %0d", $time, want.pitch,
                   $signed(m_axis_tdata[14:0]));
          n_errors++;
        end
        if ($signed(m_axis_tdata[30:15]) != want.roll) begin
          $display("%0t: roll mismatch, expected %0d, got %0d", $time, want.roll,
                   $signed(m_axis_tdata[30:15]));
          n_errors++;
        end
        if (m_axis_tdata[atp_pkg::OUT_W-1:31] != '0) begin
          $display("%0t: pad mismatch, expected 0, got %h", $time,
                   m_axis_tdata[atp_pkg::OUT_W-1:31]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random_mix(650);
    run_output_hold();
    run_back_to_back();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tilt_expected.size() != 0) @(posedge clk);
    repeat (atp_pkg::DEPTH + 10) @(posedge clk);
    $display("tb: %0d samples in, %0d angle words checked, %0d mismatches", n_sent, n_checked,
             n_errors);
    $display("tb: covered zero pairs, axis extremes, random idling and a long output stall");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
